/* rtl/char_lcd_command_sequencer_core_defines.svh */
// Assertion macros shared by the character LCD sequencer RTL.
`ifndef CHAR_LCD_COMMAND_SEQUENCER_CORE_DEFINES_SVH
`define CHAR_LCD_COMMAND_SEQUENCER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");

`endif

/* rtl/clcd_pkg.sv */
// Types, constants and helper functions of the character LCD sequencer.
package clcd_pkg;

   typedef logic [26:0] wait_type;

   localparam wait_type WAIT_NIBBLE     = 27'd500;
   localparam wait_type WAIT_SHORT      = 27'd53000;
   localparam wait_type WAIT_LONG       = 27'd3000000;
   localparam wait_type WAIT_INIT_LONG  = 27'd5000000;
   localparam wait_type WAIT_INIT_SHORT = 27'd200000;
   localparam wait_type WAIT_POWERUP    = 27'd100000000;

   // Command codes.
   localparam logic [4:0] CMD_INIT          = 5'd0;
   localparam logic [4:0] CMD_BLINK_OFF     = 5'd1;
   localparam logic [4:0] CMD_BLINK_ON      = 5'd2;
   localparam logic [4:0] CMD_CURSOR_OFF    = 5'd3;
   localparam logic [4:0] CMD_CURSOR_ON     = 5'd4;
   localparam logic [4:0] CMD_DISPLAY_OFF   = 5'd5;
   localparam logic [4:0] CMD_DISPLAY_ON    = 5'd6;
   localparam logic [4:0] CMD_CLEAR         = 5'd7;
   localparam logic [4:0] CMD_HOME          = 5'd8;
   localparam logic [4:0] CMD_CURSOR_LEFT   = 5'd9;
   localparam logic [4:0] CMD_CURSOR_RIGHT  = 5'd10;
   localparam logic [4:0] CMD_DISPLAY_LEFT  = 5'd11;
   localparam logic [4:0] CMD_DISPLAY_RIGHT = 5'd12;
   localparam logic [4:0] CMD_ENTRY_INC     = 5'd13;
   localparam logic [4:0] CMD_ENTRY_DEC     = 5'd14;
   localparam logic [4:0] CMD_SCROLL_OFF    = 5'd15;
   localparam logic [4:0] CMD_SCROLL_ON     = 5'd16;
   localparam logic [4:0] CMD_SET_POS       = 5'd17;
   localparam logic [4:0] CMD_WRITE_CHAR    = 5'd18;
   localparam logic [4:0] CMD_WRITE_HEX     = 5'd19;
   localparam logic [4:0] CMD_CLEAR_ROW     = 5'd20;

   // Register indexes of the control port.
   localparam logic [1:0] CSR_BUS_MODE    = 2'd0;
   localparam logic [1:0] CSR_TWO_LINES   = 2'd1;
   localparam logic [1:0] CSR_FONT_SELECT = 2'd2;

   // Controller instruction bytes.
   localparam logic [7:0] LCD_CLEAR    = 8'h01;
   localparam logic [7:0] LCD_HOME     = 8'h02;
   localparam logic [7:0] LCD_ENTRY    = 8'h04;
   localparam logic [7:0] LCD_DISPLAY  = 8'h08;
   localparam logic [7:0] LCD_SHIFT    = 8'h10;
   localparam logic [7:0] LCD_FUNCTION = 8'h20;
   localparam logic [7:0] LCD_DDRAM    = 8'h80;
   localparam logic [7:0] LCD_WAKE     = 8'h30;
   localparam logic [3:0] LCD_WAKE_4BIT = 4'h2;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   // Entry increment and display on, as left behind by the power-up sequence.
   localparam logic [7:0] LCD_ENTRY_INIT   = 8'h06;
   localparam logic [7:0] LCD_DISPLAY_INIT = 8'h0C;

   typedef enum logic [1:0] {
      KIND_SINGLE,
      KIND_HEX,
      KIND_ROW,
      KIND_INIT
   } kind_type;

   // What the transfer generator needs to replay one command.
   typedef struct packed {
      kind_type   kind;
      logic       mode8;
      logic       rs;
      logic       wait_long;
      logic [7:0] byte0;
      logic [7:0] byte1;
   } xfer_desc_type;

   typedef struct packed {
      logic busy;
      logic take;
   } gen_status_type;

   function automatic logic [7:0] hex_ascii(input logic [3:0] digit);
      logic [7:0] wide;
      wide = {4'h0, digit};
      return (digit < 4'd10) ? (8'h30 + wide) : (8'h37 + wide);
   endfunction

endpackage

/* rtl/clcd_if.sv */
// Valid/ready channel interfaces of the character LCD sequencer.
interface clcd_req_if;
   logic       valid;
   logic       ready;
   logic [4:0] command;
   logic [7:0] char_code;
   logic [5:0] column;
   logic       row;

   modport source(output valid, command, char_code, column, row, input ready);
   modport sink(input valid, command, char_code, column, row, output ready);
endinterface

interface clcd_rsp_if;
   logic        valid;
   logic        ready;
   logic        strobe_res;
   logic        reg_select;
   logic [7:0]  bus_value;
   logic [26:0] wait_ns;
   logic        last;

   modport source(output valid, strobe_res, reg_select, bus_value, wait_ns, last,
                  input ready);
   modport sink(input valid, strobe_res, reg_select, bus_value, wait_ns, last,
                output ready);
endinterface

interface clcd_csr_if;
   logic       valid;
   logic       ready;
   logic [1:0] index;
   logic       wdata;

   modport source(output valid, index, wdata, input ready);
   modport sink(input valid, index, wdata, output ready);
endinterface

/* rtl/char_lcd_command_sequencer_core.sv */
// Top level of the character LCD command sequencer.
// Each item on the request channel is one high-level command for an HD44780-style
// character display controller; the block answers with one result item per bus
// transfer (strobe flag, RS, bus value or nibble, wait in ns, last flag). A command
// occupies the transfer generator until all of its transfers are out, one per cycle
// when the result side is ready. Transfer counts are 1 or 2 for short commands, 2 or 4
// for a hex byte, 9 or 15 for init and DISPLAY_COLUMNS + 1 or 2 * DISPLAY_COLUMNS + 2
// for clear-row (eight-bit and four-bit bus). The next command is accepted in the same
// cycle in which the final transfer of the previous one enters the result register,
// so commands run back to back. Commands that produce nothing (a repeated init or
// an undefined code) leave the generator idle. Control registers may be written at
// any time the block is idle and are always ready.
`include "char_lcd_command_sequencer_core_defines.svh"

module char_lcd_command_sequencer_core
   import clcd_pkg::*;
#(
   parameter int DISPLAY_COLUMNS = 16
) (
   input  logic       clock,
   input  logic       reset,
   clcd_req_if.sink   req_chan,
   clcd_rsp_if.source rsp_chan,
   clcd_csr_if.sink   csr_chan
);

   // The counter must index the longest command, a four-bit clear-row.
   localparam int CNT_W = $clog2(2 * DISPLAY_COLUMNS + 2);

   logic             req_accept;
   logic             dec_load;
   xfer_desc_type    dec_desc;
   logic [CNT_W-1:0] dec_last_idx;
   gen_status_type   gen_status;

   // A new command is taken whenever the generator is idle or is handing over
   // the final transfer of its current command this cycle.
   assign req_chan.ready = gen_status.take;
   assign req_accept     = req_chan.valid && req_chan.ready;

   // The decoder updates the shadow display, entry and shift bits at acceptance
   // and turns the command into a compact description for the generator.
   clcd_decode #(
      .DISPLAY_COLUMNS(DISPLAY_COLUMNS),
      .CNT_W          (CNT_W)
   ) u_decode (
      .clock    (clock),
      .reset    (reset),
      .accept   (req_accept),
      .command  (req_chan.command),
      .char_code(req_chan.char_code),
      .column   (req_chan.column),
      .row      (req_chan.row),
      .csr_chan (csr_chan),
      .load     (dec_load),
      .desc     (dec_desc),
      .last_idx (dec_last_idx)
   );

   // The generator replays the description into the result register, one transfer per
   // cycle while the result side is ready; the register also decouples the two channels.
   clcd_xfer_gen #(
      .CNT_W(CNT_W)
   ) u_xfer_gen (
      .clock   (clock),
      .reset   (reset),
      .load    (req_accept && dec_load),
      .desc    (dec_desc),
      .last_idx(dec_last_idx),
      .status  (gen_status),
      .rsp_chan(rsp_chan)
   );

   // A command that produces transfers must keep the generator busy next cycle.
   `ASSERT_NEXT(a_load_starts, clock, reset, req_accept && dec_load, gen_status.busy)
   // A silent command taken while idle must not wake the generator.
   `ASSERT_NEXT(a_silent_idle, clock, reset, req_accept && !dec_load && !gen_status.busy,
                !gen_status.busy)
   // A command is only taken over a running one when that one is finishing.
   `ASSERT_IMPLY(a_no_overrun, clock, reset, req_accept && gen_status.busy,
                 rsp_chan.ready || !rsp_chan.valid)

endmodule

/* rtl/clcd_decode.sv */
// Command decoder with shadow state and control registers.
module clcd_decode
   import clcd_pkg::*;
#(
   parameter int DISPLAY_COLUMNS = 16,
   parameter int CNT_W           = 6
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic [4:0]         command,
   input  logic [7:0]         char_code,
   input  logic [5:0]         column,
   input  logic               row,
   clcd_csr_if.sink           csr_chan,
   output logic               load,
   output xfer_desc_type      desc,
   output logic [CNT_W-1:0]   last_idx
);

   localparam logic [CNT_W-1:0] ROW_LAST8  = CNT_W'(DISPLAY_COLUMNS);
   localparam logic [CNT_W-1:0] ROW_LAST4  = CNT_W'(2 * DISPLAY_COLUMNS + 1);
   localparam logic [CNT_W-1:0] INIT_LAST8 = CNT_W'(8);
   localparam logic [CNT_W-1:0] INIT_LAST4 = CNT_W'(14);

   logic       bus_mode_ff, two_lines_ff, font_select_ff;
   logic       initialized_ff, initialized_in;
   logic [1:0] entry_ff, entry_in;
   logic [2:0] display_ff, display_in;
   logic [1:0] shift_ff, shift_in;

   assign csr_chan.ready = 1'b1;

   always_comb begin
      initialized_in = initialized_ff;
      entry_in       = entry_ff;
      display_in     = display_ff;
      shift_in       = shift_ff;
      load           = 1'b1;
      desc.kind      = KIND_SINGLE;
      desc.mode8     = bus_mode_ff;
      desc.rs        = 1'b0;
      desc.wait_long = 1'b0;
      desc.byte0     = 8'h00;
      desc.byte1     = 8'h00;
      unique case (command)
         CMD_INIT: begin
            if (initialized_ff) begin
               load = 1'b0;
            end else begin
               initialized_in = 1'b1;
               entry_in       = 2'b10;
               display_in     = 3'b100;
               shift_in       = 2'b00;
               desc.kind      = KIND_INIT;
               desc.byte0     = LCD_FUNCTION |
                                {3'b000, bus_mode_ff, two_lines_ff, font_select_ff, 2'b00};
            end
         end
         CMD_BLINK_OFF: begin
            display_in = display_ff & 3'b110;
            desc.byte0 = LCD_DISPLAY | {5'b0, display_in};
         end
         CMD_BLINK_ON: begin
            display_in = display_ff | 3'b001;
            desc.byte0 = LCD_DISPLAY | {5'b0, display_in};
         end
         CMD_CURSOR_OFF: begin
            display_in = display_ff & 3'b101;
            desc.byte0 = LCD_DISPLAY | {5'b0, display_in};
         end
         CMD_CURSOR_ON: begin
            display_in = display_ff | 3'b010;
            desc.byte0 = LCD_DISPLAY | {5'b0, display_in};
         end
         CMD_DISPLAY_OFF: begin
            display_in = display_ff & 3'b011;
            desc.byte0 = LCD_DISPLAY | {5'b0, display_in};
         end
         CMD_DISPLAY_ON: begin
            display_in = display_ff | 3'b100;
            desc.byte0 = LCD_DISPLAY | {5'b0, display_in};
         end
         CMD_CLEAR: begin
            desc.byte0     = LCD_CLEAR;
            desc.wait_long = 1'b1;
         end
         CMD_HOME: begin
            desc.byte0     = LCD_HOME;
            desc.wait_long = 1'b1;
         end
         CMD_CURSOR_LEFT, CMD_CURSOR_RIGHT, CMD_DISPLAY_LEFT, CMD_DISPLAY_RIGHT: begin
            // The four shift codes map onto select and direction in order.
            shift_in   = command[1:0] - 2'd1;
            desc.byte0 = LCD_SHIFT | {4'b0, shift_in, 2'b00};
         end
         CMD_ENTRY_INC: begin
            entry_in   = entry_ff | 2'b10;
            desc.byte0 = LCD_ENTRY | {6'b0, entry_in};
         end
         CMD_ENTRY_DEC: begin
            entry_in   = entry_ff & 2'b01;
            desc.byte0 = LCD_ENTRY | {6'b0, entry_in};
         end
         CMD_SCROLL_OFF: begin
            entry_in   = entry_ff & 2'b10;
            desc.byte0 = LCD_ENTRY | {6'b0, entry_in};
         end
         CMD_SCROLL_ON: begin
            entry_in   = entry_ff | 2'b01;
            desc.byte0 = LCD_ENTRY | {6'b0, entry_in};
         end
         CMD_SET_POS: begin
            desc.byte0 = LCD_DDRAM | {1'b0, row, column};
         end
         CMD_WRITE_CHAR: begin
            desc.rs    = 1'b1;
            desc.byte0 = char_code;
         end
         CMD_WRITE_HEX: begin
            desc.kind  = KIND_HEX;
            desc.rs    = 1'b1;
            desc.byte0 = hex_ascii(char_code[7:4]);
            desc.byte1 = hex_ascii(char_code[3:0]);
         end
         CMD_CLEAR_ROW: begin
            desc.kind  = KIND_ROW;
            desc.byte0 = LCD_DDRAM | {1'b0, row, 6'b000000};
         end
         default: begin
            load = 1'b0;
         end
      endcase
   end

   always_comb begin
      unique case (desc.kind)
         KIND_SINGLE: last_idx = desc.mode8 ? CNT_W'(0) : CNT_W'(1);
         KIND_HEX:    last_idx = desc.mode8 ? CNT_W'(1) : CNT_W'(3);
         KIND_ROW:    last_idx = desc.mode8 ? ROW_LAST8 : ROW_LAST4;
         KIND_INIT:   last_idx = desc.mode8 ? INIT_LAST8 : INIT_LAST4;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         initialized_ff <= 1'b0;
         entry_ff       <= 2'b00;
         display_ff     <= 3'b000;
         shift_ff       <= 2'b00;
      end else if (accept) begin
         initialized_ff <= initialized_in;
         entry_ff       <= entry_in;
         display_ff     <= display_in;
         shift_ff       <= shift_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bus_mode_ff    <= 1'b0;
         two_lines_ff   <= 1'b1;
         font_select_ff <= 1'b0;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            CSR_BUS_MODE:    bus_mode_ff    <= csr_chan.wdata;
            CSR_TWO_LINES:   two_lines_ff   <= csr_chan.wdata;
            CSR_FONT_SELECT: font_select_ff <= csr_chan.wdata;
            default: begin
            end
         endcase
      end
   end

endmodule

/* rtl/clcd_xfer_gen.sv */
// Transfer generator: steps through one command and drives the result register.
`include "char_lcd_command_sequencer_core_defines.svh"

module clcd_xfer_gen
   import clcd_pkg::*;
#(
   parameter int CNT_W = 6
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             load,
   input  xfer_desc_type    desc,
   input  logic [CNT_W-1:0] last_idx,
   output gen_status_type   status,
   clcd_rsp_if.source       rsp_chan
);

   logic                busy_ff, busy_in;
   xfer_desc_type       desc_ff;
   logic [CNT_W-1:0]    last_ff;
   logic [CNT_W-1:0]    step_ff, step_in;
   logic                valid_ff;
   logic                strobe_ff, rs_ff, last_out_ff;
   logic [7:0]          value_ff;
   wait_type            wait_ff;

   logic                advance, is_last, take;
   logic [CNT_W-1:0]    pre_len, rel, bidx;
   logic                in_pre, high_half;
   logic [7:0]          cur_byte;
   logic                cur_rs, cur_long;
   logic                x_strobe, x_rs;
   logic [7:0]          x_value;
   wait_type            x_wait;

   assign advance = busy_ff && (!valid_ff || rsp_chan.ready);
   assign is_last = (step_ff == last_ff);
   assign take    = !busy_ff || (advance && is_last);

   assign status.busy = busy_ff;
   assign status.take = take;

   // Init opens with the power-up wait and the wake-up transfers.
   assign pre_len   = desc_ff.mode8 ? CNT_W'(4) : CNT_W'(5);
   assign in_pre    = (desc_ff.kind == KIND_INIT) && (step_ff < pre_len);
   assign rel       = (desc_ff.kind == KIND_INIT) ? (step_ff - pre_len) : step_ff;
   assign bidx      = desc_ff.mode8 ? rel : (rel >> 1);
   assign high_half = !desc_ff.mode8 && !rel[0];

   always_comb begin
      cur_byte = desc_ff.byte0;
      cur_rs   = desc_ff.rs;
      cur_long = desc_ff.wait_long;
      unique case (desc_ff.kind)
         KIND_SINGLE: begin
         end
         KIND_HEX: begin
            cur_byte = (bidx == CNT_W'(0)) ? desc_ff.byte0 : desc_ff.byte1;
         end
         KIND_ROW: begin
            if (bidx != CNT_W'(0)) begin
               cur_byte = CHAR_SPACE;
               cur_rs   = 1'b1;
            end
         end
         KIND_INIT: begin
            cur_rs   = 1'b0;
            cur_long = 1'b0;
            if (bidx == CNT_W'(1)) begin
               cur_byte = LCD_DISPLAY;
            end else if (bidx == CNT_W'(2)) begin
               cur_byte = LCD_CLEAR;
               cur_long = 1'b1;
            end else if (bidx == CNT_W'(3)) begin
               cur_byte = LCD_ENTRY_INIT;
            end else if (bidx == CNT_W'(4)) begin
               cur_byte = LCD_DISPLAY_INIT;
            end
         end
      endcase
   end

   always_comb begin
      x_strobe = 1'b1;
      x_rs     = cur_rs;
      if (in_pre) begin
         x_rs = 1'b0;
         if (step_ff == CNT_W'(0)) begin
            x_strobe = 1'b0;
            x_value  = 8'h00;
            x_wait   = WAIT_POWERUP;
         end else if (step_ff == CNT_W'(4)) begin
            x_value  = {4'h0, LCD_WAKE_4BIT};
            x_wait   = WAIT_SHORT;
         end else begin
            x_value  = desc_ff.mode8 ? LCD_WAKE : {4'h0, LCD_WAKE[7:4]};
            x_wait   = (step_ff == CNT_W'(1)) ? WAIT_INIT_LONG : WAIT_INIT_SHORT;
         end
      end else if (high_half) begin
         x_value = {4'h0, cur_byte[7:4]};
         x_wait  = WAIT_NIBBLE;
      end else begin
         x_value = desc_ff.mode8 ? cur_byte : {4'h0, cur_byte[3:0]};
         x_wait  = cur_long ? WAIT_LONG : WAIT_SHORT;
      end
   end

   assign busy_in = take ? load : busy_ff;

   always_comb begin
      if (take) begin
         step_in = '0;
      end else if (advance) begin
         step_in = step_ff + 1'b1;
      end else begin
         step_in = step_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         if (advance) begin
            valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      if (take && load) begin
         desc_ff <= desc;
         last_ff <= last_idx;
      end
      if (advance) begin
         strobe_ff   <= x_strobe;
         rs_ff       <= x_rs;
         value_ff    <= x_value;
         wait_ff     <= x_wait;
         last_out_ff <= is_last;
      end
   end

   assign rsp_chan.valid      = valid_ff;
   assign rsp_chan.strobe_res = strobe_ff;
   assign rsp_chan.reg_select = rs_ff;
   assign rsp_chan.bus_value  = value_ff;
   assign rsp_chan.wait_ns    = wait_ff;
   assign rsp_chan.last       = last_out_ff;

   // Within one command the transfer index moves up by one per emitted transfer.
   `ASSERT_NEXT(a_step_counts, clock, reset, advance && !is_last,
                step_ff == CNT_W'($past(step_ff) + 1'b1))

endmodule
